// ----- rtl/bsmmd_pkg.sv -----
`timescale 1ns / 1ps

package bsmmd_pkg;

    localparam int HIGH_RAM_BYTES = 127;
    localparam int IO_REG_COUNT   = 128;

    // internal register file: io entries, high ram and interrupt enable byte
    localparam int RF_DEPTH = 256;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    localparam int IN_W   = 40;
    localparam int OUT_W  = 40;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [2:0] {
        REGION_BOOT = 3'd0,
        REGION_ROM  = 3'd1,
        REGION_VRAM = 3'd2,
        REGION_CRAM = 3'd3,
        REGION_WRAM = 3'd4,
        REGION_OAM  = 3'd5,
        REGION_INT  = 3'd6,
        REGION_OPEN = 3'd7
    } region_t;

    localparam logic [CFG_AW-1:0] CFG_MAPPER_EN    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MULTICART    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ROM_BITS     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_RAM_PRESENT  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RAM_BYTES    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_BOOT_PRESENT = 3'd5;

    localparam logic [6:0] IO_JOYP     = 7'h00;
    localparam logic [6:0] IO_DIV      = 7'h04;
    localparam logic [6:0] IO_TIMA     = 7'h05;
    localparam logic [6:0] IO_TMA      = 7'h06;
    localparam logic [6:0] IO_TAC      = 7'h07;
    localparam logic [6:0] IO_LY       = 7'h44;
    localparam logic [6:0] IO_BOOT_OFF = 7'h50;
    localparam logic [6:0] IO_IE_ALIAS = 7'h7F;

    localparam logic [RF_AW-1:0] RF_IE_INDEX = 8'hFF;

    localparam logic [15:0] ADDR_DIV = 16'hFF04;
    localparam logic [15:0] ADDR_TAC = 16'hFF07;

    // read fill per io entry; 0xFF marks an entry with no register
    localparam logic [7:0] IO_FILL [IO_REG_COUNT] = '{
        8'h00,8'h00,8'h7E,8'hFF,8'h00,8'h00,8'h00,8'hF8,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hE0,
        8'h80,8'h00,8'h00,8'h00,8'h00,8'hFF,8'h00,8'h00,
        8'h00,8'h00,8'h7F,8'h00,8'h9F,8'h00,8'h00,8'hFF,
        8'hC0,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h70,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h80,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF
    };

endpackage

// ----- rtl/bank_switch_memory_map_decoder.sv -----
`timescale 1ns / 1ps

// a transaction accepted into the input stage is decoded there and leaves from the result register
// throughput: one transaction per cycle; stalls only while the result register is held
// the internal register file is read at accept and its data registered for the decode stage
// reset: aresetn synchronous active low; resets control state, bank registers,
// io timer/joypad registers and clears the 256 valid bits of the internal register file
module bank_switch_memory_map_decoder
    import bsmmd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // operation, address[15:0], write_data[7:0], buttons[7:0], zero pad
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // region[2:0], mem_address[20:0], mem_write, read_data[7:0],
    // divider_clear, prescaler_clear, zero pad
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    logic        in_op;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    logic [7:0]  in_keys;
    logic        s_fire;
    logic        advance;

    logic mapper_en_reg, multicart_reg, ram_present_reg, boot_present_reg;
    logic [2:0]  rom_bits_reg;
    logic [15:0] ram_bytes_reg;

    logic [4:0] low_bank_reg;
    logic [1:0] upper_bank_reg;
    logic       banking_mode_reg, ram_gate_reg, boot_on_reg;

    logic [1:0] joyp_sel_reg;
    logic [7:0] tima_reg, tma_reg;
    logic [2:0] tac_reg;

    logic [7:0]          rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] rf_vld_reg;
    logic [7:0]          rf_rdata_reg;
    logic                rf_rvld_reg;
    logic [RF_AW-1:0]    rf_idx;
    logic                rf_we;

    logic        a_vld_reg, a_op_reg;
    logic [15:0] a_addr_reg;
    logic [7:0]  a_keys_reg;

    logic        m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    region_t     region;
    logic [20:0] maddr;
    logic        mwr;
    logic [7:0]  rdata;
    logic        div_clr, pre_clr;
    logic [7:0]  rom_mask, rom_page, up_shift, low_sel;
    logic [14:0] cram_addr;
    logic [7:0]  rf_word, fill;
    logic [3:0]  nib;
    logic [6:0]  io_r;

    assign in_op    = s_tdata[0];
    assign in_addr  = s_tdata[16:1];
    assign in_wdata = s_tdata[24:17];
    assign in_keys  = s_tdata[32:25];

    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = !a_vld_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_en_reg    <= 1'b1;
            multicart_reg    <= 1'b0;
            rom_bits_reg     <= 3'd6;
            ram_present_reg  <= 1'b0;
            ram_bytes_reg    <= '0;
            boot_present_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAPPER_EN:    mapper_en_reg    <= cfg_data[0];
                CFG_MULTICART:    multicart_reg    <= cfg_data[0];
                CFG_ROM_BITS:     rom_bits_reg     <= cfg_data[2:0];
                CFG_RAM_PRESENT:  ram_present_reg  <= cfg_data[0];
                CFG_RAM_BYTES:    ram_bytes_reg    <= cfg_data;
                CFG_BOOT_PRESENT: boot_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state updates take effect at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_bank_reg     <= 5'd1;
            upper_bank_reg   <= '0;
            banking_mode_reg <= 1'b0;
            ram_gate_reg     <= 1'b0;
            boot_on_reg      <= 1'b1;
            joyp_sel_reg     <= '0;
            tima_reg         <= '0;
            tma_reg          <= '0;
            tac_reg          <= '0;
        end else if (s_fire && in_op) begin
            if (!in_addr[15] && mapper_en_reg) begin
                unique case (in_addr[14:13])
                    2'd0: ram_gate_reg <= (in_wdata[3:0] == 4'hA);
                    2'd1: low_bank_reg <= (in_wdata[4:0] == 5'd0) ? 5'd1 : in_wdata[4:0];
                    2'd2: upper_bank_reg <= in_wdata[1:0];
                    2'd3: banking_mode_reg <= in_wdata[0];
                    default: ;
                endcase
            end else if (in_addr[15:7] == 9'h1FE) begin
                unique case (in_addr[6:0])
                    IO_JOYP:     joyp_sel_reg <= in_wdata[5:4];
                    IO_TIMA:     tima_reg <= in_wdata;
                    IO_TMA: begin
                        tma_reg <= in_wdata;
                        if (tima_reg == 8'd0) begin
                            tima_reg <= in_wdata;
                        end
                    end
                    IO_TAC:      tac_reg <= in_wdata[2:0];
                    IO_BOOT_OFF: boot_on_reg <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // register file: io entries at 0x00-0x7E, high ram at 0x80-0xFE, interrupt enable at 0xFF
    always_comb begin
        rf_idx = in_addr[7:0];
        if (in_addr[7:0] == {1'b0, IO_IE_ALIAS} || in_addr[7:0] == 8'hFF) begin
            rf_idx = RF_IE_INDEX;
        end
        rf_we = s_fire && in_op && (in_addr[15:8] == 8'hFF);
        if (in_addr[15:7] == 9'h1FE) begin
            priority case (in_addr[6:0])
                IO_JOYP, IO_DIV, IO_TIMA, IO_TMA, IO_TAC, IO_LY, IO_BOOT_OFF: rf_we = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_idx] <= in_wdata;
        end
        if (s_fire) begin
            rf_rdata_reg <= rf_mem[rf_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg  <= '0;
            rf_rvld_reg <= 1'b0;
        end else begin
            if (rf_we) begin
                rf_vld_reg[rf_idx] <= 1'b1;
            end
            if (s_fire) begin
                rf_rvld_reg <= rf_vld_reg[rf_idx];
            end
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (s_tready) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_op_reg   <= in_op;
            a_addr_reg <= in_addr;
            a_keys_reg <= in_keys;
        end
    end

    // decode
    always_comb begin
        rom_mask  = 8'((9'd1 << ({1'b0, rom_bits_reg} + 4'd1)) - 9'd1);
        up_shift  = multicart_reg ? {2'b00, upper_bank_reg, 4'b0000}
                                  : {1'b0, upper_bank_reg, 5'b00000};
        low_sel   = multicart_reg ? {4'b0000, low_bank_reg[3:0]} : {3'b000, low_bank_reg};
        if (!a_addr_reg[14]) begin
            rom_page = banking_mode_reg ? up_shift : 8'd0;
        end else begin
            rom_page = up_shift | low_sel;
        end
        rom_page  = rom_page & rom_mask;
        cram_addr = {banking_mode_reg ? upper_bank_reg : 2'b00, a_addr_reg[12:0]};
        rf_word   = rf_rvld_reg ? rf_rdata_reg : 8'd0;
        io_r      = a_addr_reg[6:0];
        fill      = IO_FILL[io_r];
        nib       = 4'hF;
        if (!joyp_sel_reg[0]) begin
            nib = a_keys_reg[3:0];
        end
        if (!joyp_sel_reg[1]) begin
            nib = a_keys_reg[7:4];
        end

        region  = REGION_OPEN;
        maddr   = '0;
        mwr     = 1'b0;
        rdata   = 8'hFF;
        div_clr = a_op_reg && (a_addr_reg == ADDR_DIV);
        pre_clr = a_op_reg && (a_addr_reg == ADDR_TAC);

        priority if (!a_addr_reg[15]) begin
            if (a_op_reg) begin
                region = REGION_ROM;
            end else if (a_addr_reg[15:8] == 8'h00 && boot_on_reg && boot_present_reg) begin
                region = REGION_BOOT;
                maddr  = {13'd0, a_addr_reg[7:0]};
            end else begin
                region = REGION_ROM;
                maddr  = mapper_en_reg ? {rom_page[6:0], a_addr_reg[13:0]}
                                       : {5'd0, a_addr_reg};
            end
        end else if (a_addr_reg < 16'hA000) begin
            region = REGION_VRAM;
            maddr  = {8'd0, a_addr_reg[12:0]};
            mwr    = a_op_reg;
        end else if (a_addr_reg < 16'hC000) begin
            if (ram_gate_reg && ram_present_reg) begin
                region = REGION_CRAM;
                maddr  = {6'd0, cram_addr};
                mwr    = a_op_reg && ({1'b0, cram_addr} < ram_bytes_reg);
            end
        end else if (a_addr_reg < 16'hE000) begin
            region = REGION_WRAM;
            maddr  = {8'd0, a_addr_reg[12:0]};
            mwr    = a_op_reg;
        end else if (a_addr_reg < 16'hFE00) begin
            region = REGION_WRAM;
            maddr  = {8'd0, a_addr_reg[12:0]};
            mwr    = a_op_reg;
        end else if (a_addr_reg < 16'hFEA0) begin
            region = REGION_OAM;
            maddr  = {13'd0, a_addr_reg[7:0]};
            mwr    = a_op_reg;
        end else if (a_addr_reg < 16'hFF00) begin
            region = REGION_OPEN;
        end else if (a_op_reg) begin
            region = REGION_INT;
        end else if (a_addr_reg[7] || a_addr_reg[7:0] == 8'hFF) begin
            region = REGION_INT;
            rdata  = rf_word;
        end else if (fill == 8'hFF) begin
            region = REGION_OPEN;
        end else begin
            region = REGION_INT;
            unique case (io_r)
                IO_JOYP: rdata = {2'b11, joyp_sel_reg, nib};
                IO_DIV:  rdata = fill;
                IO_TIMA: rdata = tima_reg | fill;
                IO_TMA:  rdata = tma_reg | fill;
                IO_TAC:  rdata = {5'd0, tac_reg} | fill;
                IO_LY:   rdata = fill;
                default: rdata = rf_word | fill;
            endcase
        end

        if ((region != REGION_INT && region != REGION_OPEN) || a_op_reg) begin
            rdata = 8'd0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && a_vld_reg) begin
            m_tdata_reg <= {5'd0, pre_clr, div_clr, rdata, mwr, maddr, region};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_low_bank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        low_bank_reg != 5'd0)
        else $error("low bank register holds zero");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && a_vld_reg |-> advance)
        else $error("input stage overwritten while result held");

    a_open_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == REGION_OPEN || m_tdata[2:0] == REGION_INT)
        |-> m_tdata[23:3] == 21'd0 && !m_tdata[24])
        else $error("internal or open result drives external memory");

    a_write_external: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> m_tdata[32:25] == 8'd0
        && m_tdata[2:0] != REGION_BOOT && m_tdata[2:0] != REGION_ROM)
        else $error("memory write on a read-only region");

    a_single_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("both timer clears in one result");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bsmmd_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam int PHASE_ACCESSES = 240;
    localparam int HOLDOFF_AFTER  = 600;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;

    // read fill of each io entry, 0xFF where no register exists
    localparam logic [7:0] IO_READ_FILL [128] = '{
        8'h00,8'h00,8'h7E,8'hFF,8'h00,8'h00,8'h00,8'hF8,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hE0,
        8'h80,8'h00,8'h00,8'h00,8'h00,8'hFF,8'h00,8'h00,8'h00,8'h00,8'h7F,8'h00,8'h9F,8'h00,8'h00,8'hFF,
        8'hC0,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h70,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h80,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF
    };

    localparam logic [15:0] HOT_IO_ADDRS [11] = '{
        16'hFF00, 16'hFF04, 16'hFF05, 16'hFF06, 16'hFF07, 16'hFF44,
        16'hFF46, 16'hFF0F, 16'hFF50, 16'hFF7F, 16'hFF03
    };

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  keys;
    } bus_access_t;

    typedef struct packed {
        region_t     region;
        logic [20:0] mem_address;
        logic        mem_write;
        logic [7:0]  read_data;
        logic        divider_clear;
        logic        prescaler_clear;
    } decode_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    bank_switch_memory_map_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // register settings as seen by the predictor
    logic        map_en        = 1'b1;
    logic        map_multicart = 1'b0;
    logic [2:0]  rom_size_code = 3'd6;
    logic        cram_fitted   = 1'b0;
    logic [15:0] cram_size     = 16'd0;
    logic        boot_fitted   = 1'b1;

    // predicted block state
    logic [7:0] io_regs [128];
    logic [7:0] hram [127];
    logic [4:0] low_bank;
    logic [1:0] upper_bank;
    logic       banking_mode;
    logic       ram_gate;
    logic       boot_overlay;

    bus_access_t    pending_accesses [$];
    decode_result_t expected_decodes [$];
    bus_access_t    cur_access;

    bit boot_off_allowed = 1'b0;
    int mismatches = 0;
    int accepted = 0;
    int writes_accepted = 0;
    int results_seen = 0;
    int settings_applied = 0;
    int region_hits [8];
    longint cycle_count = 0;

    function automatic decode_result_t decode_access(bus_access_t acc);
        decode_result_t res;
        logic [6:0]  r;
        logic [7:0]  sel;
        logic [3:0]  nib;
        logic [31:0] ub, bank, mask, lin;
        int          shift;
        logic        wr;
        wr = (acc.op == OP_WRITE);
        res = '{REGION_OPEN, 21'd0, 1'b0, 8'hFF, 1'b0, 1'b0};
        if (acc.addr < 16'h8000) begin
            if (wr) begin
                res.region = REGION_ROM;
                if (map_en) begin
                    if (acc.addr < 16'h2000) begin
                        ram_gate = (acc.data[3:0] == 4'hA);
                    end else if (acc.addr < 16'h4000) begin
                        low_bank = acc.data[4:0];
                        if (low_bank == 5'd0) low_bank = 5'd1;
                    end else if (acc.addr < 16'h6000) begin
                        upper_bank = acc.data[1:0];
                    end else begin
                        banking_mode = acc.data[0];
                    end
                end
            end else if (acc.addr < 16'h0100 && boot_overlay && boot_fitted) begin
                res.region = REGION_BOOT;
                res.mem_address = 21'(acc.addr);
            end else begin
                res.region = REGION_ROM;
                if (map_en) begin
                    ub = 32'(upper_bank);
                    shift = map_multicart ? 4 : 5;
                    mask = ((32'd1 << (rom_size_code + 1)) - 1) & 32'hFF;
                    if (acc.addr < 16'h4000) begin
                        bank = banking_mode ? (ub << shift) : 32'd0;
                    end else begin
                        bank = (ub << shift) | (low_bank & (map_multicart ? 5'h0F : 5'h1F));
                    end
                    lin = (bank & mask) * 32'h4000 + acc.addr[13:0];
                    res.mem_address = lin[20:0];
                end else begin
                    res.mem_address = 21'(acc.addr);
                end
            end
        end else if (acc.addr < 16'hA000) begin
            res.region = REGION_VRAM;
            res.mem_address = 21'(acc.addr - 16'h8000);
            res.mem_write = wr;
        end else if (acc.addr < 16'hC000) begin
            if (ram_gate && cram_fitted) begin
                lin = (banking_mode ? upper_bank * 32'h2000 : 32'd0) + (acc.addr - 16'hA000);
                res.region = REGION_CRAM;
                res.mem_address = lin[20:0];
                res.mem_write = wr && (lin < cram_size);
            end
        end else if (acc.addr < 16'hE000) begin
            res.region = REGION_WRAM;
            res.mem_address = 21'(acc.addr - 16'hC000);
            res.mem_write = wr;
        end else if (acc.addr < 16'hFE00) begin
            res.region = REGION_WRAM;
            res.mem_address = 21'(acc.addr - 16'hE000);
            res.mem_write = wr;
        end else if (acc.addr < 16'hFEA0) begin
            res.region = REGION_OAM;
            res.mem_address = 21'(acc.addr - 16'hFE00);
            res.mem_write = wr;
        end else if (acc.addr < 16'hFF00) begin
            res.region = REGION_OPEN;
        end else if (wr) begin
            res.region = REGION_INT;
            r = acc.addr[6:0];
            if (acc.addr < 16'hFF80) begin
                case (r)
                    IO_JOYP: io_regs[IO_JOYP] = acc.data & 8'h30;
                    IO_DIV: begin
                        io_regs[IO_DIV] = 8'd0;
                        res.divider_clear = 1'b1;
                    end
                    IO_TMA: begin
                        io_regs[IO_TMA] = acc.data;
                        if (io_regs[IO_TIMA] == 8'd0) io_regs[IO_TIMA] = acc.data;
                    end
                    IO_TAC: begin
                        io_regs[IO_TAC] = acc.data & 8'h07;
                        res.prescaler_clear = 1'b1;
                    end
                    IO_LY: io_regs[IO_LY] = 8'd0;
                    IO_BOOT_OFF: boot_overlay = 1'b0;
                    default: io_regs[r] = acc.data;
                endcase
            end else if (acc.addr < 16'hFFFF) begin
                hram[acc.addr[6:0]] = acc.data;
            end else begin
                io_regs[IO_IE_ALIAS] = acc.data;
            end
        end else if (acc.addr == 16'hFF00) begin
            sel = io_regs[IO_JOYP] & 8'h30;
            nib = 4'hF;
            if (!sel[4]) nib = acc.keys[3:0];
            if (!sel[5]) nib = acc.keys[7:4];
            res.region = REGION_INT;
            res.read_data = 8'hC0 | sel | nib;
        end else if (acc.addr < 16'hFF80) begin
            r = acc.addr[6:0];
            if (IO_READ_FILL[r] != 8'hFF) begin
                res.region = REGION_INT;
                res.read_data = io_regs[r] | IO_READ_FILL[r];
            end
        end else if (acc.addr < 16'hFFFF) begin
            res.region = REGION_INT;
            res.read_data = hram[acc.addr[6:0]];
        end else begin
            res.region = REGION_INT;
            res.read_data = io_regs[IO_IE_ALIAS];
        end
        if (res.region != REGION_INT && res.region != REGION_OPEN) res.read_data = 8'd0;
        if (wr) res.read_data = 8'd0;
        if (res.region == REGION_INT || res.region == REGION_OPEN) res.mem_address = 21'd0;
        return res;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] rand_addr(input int lo, input int hi);
        return 16'($urandom_range(lo, hi));
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_decodes.push_back(decode_access(cur_access));
                accepted++;
                if (cur_access.op == OP_WRITE) writes_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    cur_access = pending_accesses.pop_front();
                    s_tdata <= {7'd0, cur_access.keys, cur_access.data,
                                cur_access.addr, cur_access.op};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    logic [15:0] stall_pat = 16'hFFFF;
    int pat_left = 0;
    int taken = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) taken++;
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else if (!holdoff_done && taken >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                m_tready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_left = $urandom_range(20, 120);
                    if ($urandom_range(0, 3) == 0) stall_pat = 16'hFFFF;
                    else stall_pat = 16'($urandom) | 16'h0101;
                end else begin
                    pat_left--;
                end
                stall_pat = {stall_pat[14:0], stall_pat[15]};
                m_tready <= stall_pat[0];
            end
        end
    end

    decode_result_t got_decode, want_decode;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_decode = '{region_t'(m_tdata[2:0]), m_tdata[23:3], m_tdata[24],
                           m_tdata[32:25], m_tdata[33], m_tdata[34]};
            results_seen++;
            region_hits[m_tdata[2:0]]++;
            if (expected_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transaction %0d: region %0d addr %06h", results_seen,
                             got_decode.region, got_decode.mem_address);
            end else begin
                want_decode = expected_decodes.pop_front();
                if (got_decode != want_decode) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch at transaction %0d: expected region %0d addr %06h ",
                                  "wr %0b rd %02h dclr %0b pclr %0b, got region %0d addr %06h ",
                                  "wr %0b rd %02h dclr %0b pclr %0b"}, results_seen,
                                 want_decode.region, want_decode.mem_address,
                                 want_decode.mem_write, want_decode.read_data,
                                 want_decode.divider_clear, want_decode.prescaler_clear,
                                 got_decode.region, got_decode.mem_address,
                                 got_decode.mem_write, got_decode.read_data,
                                 got_decode.divider_clear, got_decode.prescaler_clear);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] data, input logic [7:0] keys);
        bus_access_t acc;
        acc = '{op, addr, data, keys};
        if (op == OP_WRITE && addr == 16'hFF50 && !boot_off_allowed) acc.op = OP_READ;
        pending_accesses.push_back(acc);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAPPER_EN:    map_en = val[0];
            CFG_MULTICART:    map_multicart = val[0];
            CFG_ROM_BITS:     rom_size_code = val[2:0];
            CFG_RAM_PRESENT:  cram_fitted = val[0];
            CFG_RAM_BYTES:    cram_size = val;
            CFG_BOOT_PRESENT: boot_fitted = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic mapper, input logic multicart,
                                  input logic [2:0] rom_bits, input logic ram_present,
                                  input logic [15:0] ram_bytes, input logic boot_present);
        write_reg(CFG_MAPPER_EN, 16'(mapper));
        write_reg(CFG_MULTICART, 16'(multicart));
        write_reg(CFG_ROM_BITS, 16'(rom_bits));
        write_reg(CFG_RAM_PRESENT, 16'(ram_present));
        write_reg(CFG_RAM_BYTES, ram_bytes);
        write_reg(CFG_BOOT_PRESENT, 16'(boot_present));
        settings_applied++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_accesses.size() != 0 || s_tvalid || expected_decodes.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    task automatic queue_random_accesses(input int count);
        int          target;
        int          n;
        logic [15:0] a;
        logic [7:0]  d;
        logic        op;
        target = pending_accesses.size() + count;
        while (pending_accesses.size() < target) begin
            d = rand_byte();
            op = rand_bit();
            case ($urandom_range(0, 9))
                0: begin
                    if (rand_bit()) d[3:0] = 4'hA;
                    push_access(OP_WRITE, rand_addr(0, 16'h7FFF), d, rand_byte());
                end
                1, 2: begin
                    a = ($urandom_range(0, 3) == 0) ? rand_addr(0, 16'h01FF)
                                                    : rand_addr(0, 16'h7FFF);
                    push_access(OP_READ, a, d, rand_byte());
                end
                3: begin
                    // open the ram gate, maybe switch banks, then a run of cart ram accesses
                    d[3:0] = 4'hA;
                    push_access(OP_WRITE, rand_addr(0, 16'h1FFF), d, rand_byte());
                    if (rand_bit())
                        push_access(OP_WRITE, rand_addr(16'h4000, 16'h5FFF),
                                    rand_byte(), rand_byte());
                    if ($urandom_range(0, 2) == 0)
                        push_access(OP_WRITE, rand_addr(16'h6000, 16'h7FFF),
                                    rand_byte(), rand_byte());
                    n = $urandom_range(2, 8);
                    repeat (n)
                        push_access(rand_bit(), rand_addr(16'hA000, 16'hBFFF),
                                    rand_byte(), rand_byte());
                    if ($urandom_range(0, 3) == 0) begin
                        d = rand_byte();
                        if (d[3:0] == 4'hA) d[3:0] = 4'h0;
                        push_access(OP_WRITE, rand_addr(0, 16'h1FFF), d, rand_byte());
                    end
                end
                4: push_access(op, rand_addr(16'h8000, 16'hFEFF), d, rand_byte());
                5, 6: begin
                    a = (rand_bit()) ? HOT_IO_ADDRS[$urandom_range(0, 10)]
                                     : rand_addr(16'hFF00, 16'hFF7F);
                    push_access(op, a, d, rand_byte());
                end
                7: push_access(op, rand_addr(16'hFF80, 16'hFFFF), d, rand_byte());
                8: push_access(op, rand_addr(0, 16'hFFFF), d, rand_byte());
                default: begin
                    push_access(OP_WRITE, 16'hFF00, d, rand_byte());
                    n = $urandom_range(1, 3);
                    repeat (n)
                        push_access(OP_READ, 16'hFF00, rand_byte(), rand_byte());
                end
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < 128; i++) io_regs[i] = 8'd0;
        for (int i = 0; i < 127; i++) hram[i] = 8'd0;
        for (int i = 0; i < 8; i++) region_hits[i] = 0;
        low_bank = 5'd1;
        upper_bank = 2'd0;
        banking_mode = 1'b0;
        ram_gate = 1'b0;
        boot_overlay = 1'b1;

        // directed accesses under reset settings
        push_access(OP_READ,  16'h0000, 8'h00, 8'hFF);
        push_access(OP_READ,  16'h00FF, 8'h00, 8'hFF);
        push_access(OP_READ,  16'h0100, 8'h00, 8'hFF);
        push_access(OP_WRITE, 16'h2000, 8'h00, 8'h00);
        push_access(OP_READ,  16'h7FFF, 8'h00, 8'h00);
        push_access(OP_WRITE, 16'h3FFF, 8'hFF, 8'h00);
        push_access(OP_WRITE, 16'h5FFF, 8'hFF, 8'h00);
        push_access(OP_WRITE, 16'h7FFF, 8'hFF, 8'h00);
        push_access(OP_READ,  16'h3FFF, 8'h00, 8'h00);
        push_access(OP_READ,  16'h4000, 8'h00, 8'h00);
        push_access(OP_WRITE, 16'h1FFF, 8'hFA, 8'h00);
        push_access(OP_WRITE, 16'hBFFF, 8'hFF, 8'h00);
        push_access(OP_WRITE, 16'h8000, 8'hA5, 8'h00);
        push_access(OP_READ,  16'hDFFF, 8'h00, 8'h00);
        push_access(OP_WRITE, 16'hFDFF, 8'h3C, 8'h00);
        push_access(OP_READ,  16'hFE9F, 8'h00, 8'h00);
        push_access(OP_WRITE, 16'hFEA0, 8'hFF, 8'h00);
        push_access(OP_WRITE, 16'hFF00, 8'hEF, 8'h00);
        push_access(OP_READ,  16'hFF00, 8'h00, 8'h5A);
        push_access(OP_WRITE, 16'hFF06, 8'h80, 8'h00);
        push_access(OP_READ,  16'hFF05, 8'h00, 8'h00);
        push_access(OP_WRITE, 16'hFF04, 8'hFF, 8'h00);
        push_access(OP_WRITE, 16'hFF07, 8'hFF, 8'h00);
        push_access(OP_WRITE, 16'hFF44, 8'hFF, 8'h00);
        push_access(OP_READ,  16'hFF50, 8'h00, 8'h00);
        push_access(OP_WRITE, 16'hFFFF, 8'hFF, 8'h00);
        push_access(OP_READ,  16'hFFFF, 8'h00, 8'h00);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        apply_settings(1'b1, 1'b0, 3'd6, 1'b1, 16'h8000, 1'b1);
        queue_random_accesses(PHASE_ACCESSES);
        wait_idle();

        apply_settings(1'b1, 1'b1, 3'd0, 1'b1, 16'h0000, 1'b1);
        queue_random_accesses(PHASE_ACCESSES);
        wait_idle();

        apply_settings(1'b0, 1'b0, 3'd3, 1'b0, 16'h2000, 1'b0);
        queue_random_accesses(PHASE_ACCESSES);
        wait_idle();

        repeat (2) begin
            apply_settings(rand_bit(), rand_bit(), 3'($urandom_range(0, 6)),
                           1'b1, rand_addr(0, 16'h8000), rand_bit());
            queue_random_accesses(PHASE_ACCESSES);
            wait_idle();
        end

        // last phase turns the boot overlay off partway through
        apply_settings(1'b1, rand_bit(), 3'd6, 1'b1,
                       16'(16'h2000 * $urandom_range(1, 4)), 1'b1);
        queue_random_accesses(PHASE_ACCESSES / 2);
        boot_off_allowed = 1'b1;
        push_access(OP_WRITE, 16'hFF50, 8'h01, 8'h00);
        queue_random_accesses(PHASE_ACCESSES / 2);
        wait_idle();
        repeat (10) @(negedge aclk);

        $display("covered %0d bus transactions (%0d writes) over %0d register settings",
                 accepted, writes_accepted, settings_applied);
        $display("results per region boot..open: %0d %0d %0d %0d %0d %0d %0d %0d",
                 region_hits[0], region_hits[1], region_hits[2], region_hits[3],
                 region_hits[4], region_hits[5], region_hits[6], region_hits[7]);
        if (mismatches == 0 && expected_decodes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
